FILE: design/tfn_pkg.sv
// shared types and constants for the triangle face normal and box uv unit
package tfn_pkg;

   localparam int COORD_W             = 16;
   localparam int TEX_W               = 15;
   localparam int IDX_OUT_W           = 16;
   localparam int REQ_DATA_W          = 144;
   localparam int RSP_DATA_W          = 144;
   localparam int DEF_INDEX_WIDTH     = 16;
   localparam int DEF_COORD_FRAC_BITS = 14;
   localparam int QUEUE_DEPTH         = 2;
   localparam int VERTS               = 3;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   // one finished triangle: positions [vertex][axis], normal, texture axis, zero-area and start-of-mesh flags
   typedef struct packed {
      logic [VERTS-1:0][2:0][COORD_W-1:0] pos;
      logic [2:0][COORD_W-1:0]            normal;
      axis_type                           axis;
      logic                               degen;
      logic                               start;
   } tri_rec_type;

endpackage

FILE: design/tfn_front.sv
// front end: takes a triangle request and works out its unit face normal
module tfn_front #(
   parameter int COORD_FRAC_BITS = tfn_pkg::DEF_COORD_FRAC_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [tfn_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                          req_tuser,
   output logic                          rec_valid,
   input  logic                          rec_ready,
   output tfn_pkg::tri_rec_type          rec
);
   import tfn_pkg::*;

   localparam int F        = COORD_FRAC_BITS;
   localparam int DIFF_W   = 17;
   localparam int PROD_W   = 34;
   localparam int CROSS_W  = 35;
   localparam int MAG_W    = 34;
   localparam int NMAG_W   = 30;
   localparam int SQ_W     = 60;
   localparam int SUM_W    = 62;
   localparam int ROOT_W   = 31;
   localparam int SREM_W   = 36;
   localparam int NUM_W    = NMAG_W + 1 + F;
   localparam int QW       = F + 1;
   localparam int NRM_W    = (F + 2 > COORD_W) ? F + 2 : COORD_W;
   localparam int STEP_W   = 5;
   localparam logic [STEP_W-1:0] CROSS_LAST  = STEP_W'(6);
   localparam logic [STEP_W-1:0] SQUARE_LAST = STEP_W'(3);
   localparam logic [STEP_W-1:0] SQRT_LAST   = STEP_W'(30);
   localparam logic [STEP_W-1:0] DIV_LAST    = STEP_W'(F);
   localparam logic [MAG_W-1:0]  NORM_HI     = MAG_W'(1) << 30;
   localparam logic [MAG_W-1:0]  NORM_LO     = MAG_W'(1) << 29;

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_CROSS  = 9'b000000010,
      S_ABS    = 9'b000000100,
      S_MAX    = 9'b000001000,
      S_NORM   = 9'b000010000,
      S_SQUARE = 9'b000100000,
      S_SQRT   = 9'b001000000,
      S_DLOAD  = 9'b010000000,
      S_DIV    = 9'b100000000
   } state_type;

   localparam state_type S_PUSH_UNUSED = S_IDLE;

   typedef struct packed {
      logic [VERTS-1:0][2:0][COORD_W-1:0] pos;
      logic                               start;
      logic [2:0][DIFF_W-1:0]             d1;
      logic [2:0][DIFF_W-1:0]             d2;
      logic [PROD_W-1:0]                  prod;
      logic                               prod_vld;
      logic [2:0]                         prod_idx;
      logic [2:0][CROSS_W-1:0]            c;
      logic [2:0][MAG_W-1:0]              m;
      logic [2:0]                         neg;
      logic [MAG_W-1:0]                   mx;
      logic                               degen;
      logic [SQ_W-1:0]                    sq;
      logic                               sq_vld;
      logic [SUM_W-1:0]                   sum;
      logic [SUM_W-1:0]                   x;
      logic [ROOT_W-1:0]                  root;
      logic [SREM_W-1:0]                  srem;
      logic [ROOT_W-1:0]                  rem;
      logic [QW-1:0]                      qsh;
      logic [2:0][QW-1:0]                 q;
      logic [STEP_W-1:0]                  step;
      logic [1:0]                         comp;
      logic                               done;
   } dp_type;

   state_type state_ff, state_in;
   dp_type    dp_ff, dp_in;

   logic signed [DIFF_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [CROSS_W-1:0] acc_old, acc_new;
   logic [1:0]                acc_idx;
   logic [MAG_W-1:0]          mx01, mxa;
   logic [NMAG_W-1:0]         sq_op;
   logic [SREM_W-1:0]         srem_cat, trial;
   logic [NMAG_W-1:0]         dv_m;
   logic [NUM_W-1:0]          num;
   logic [ROOT_W:0]           rcat, rdiv;
   logic                      dge;
   logic [NRM_W-1:0]          qext;
   logic [NRM_W-1:0]          nfull;
   logic [QW-1:0]             qx, qy, qz;

   assign req_tready = (state_ff == S_IDLE) && !dp_ff.done;
   assign rec_valid  = dp_ff.done;
   assign mul_p      = mul_a * mul_b;

   always_comb begin
      unique case (dp_ff.step[2:0])
         3'd0:    begin mul_a = dp_ff.d1[1]; mul_b = dp_ff.d2[2]; end
         3'd1:    begin mul_a = dp_ff.d1[2]; mul_b = dp_ff.d2[1]; end
         3'd2:    begin mul_a = dp_ff.d1[2]; mul_b = dp_ff.d2[0]; end
         3'd3:    begin mul_a = dp_ff.d1[0]; mul_b = dp_ff.d2[2]; end
         3'd4:    begin mul_a = dp_ff.d1[0]; mul_b = dp_ff.d2[1]; end
         3'd5:    begin mul_a = dp_ff.d1[1]; mul_b = dp_ff.d2[0]; end
         default: begin mul_a = '0;          mul_b = '0;          end
      endcase
   end

   always_comb begin
      acc_idx = dp_ff.prod_idx[2:1];
      acc_old = $signed(dp_ff.c[acc_idx]);
      acc_new = dp_ff.prod_idx[0] ? acc_old - CROSS_W'($signed(dp_ff.prod))
                                  : CROSS_W'($signed(dp_ff.prod));
      mx01    = (dp_ff.m[0] >= dp_ff.m[1]) ? dp_ff.m[0] : dp_ff.m[1];
      mxa     = (mx01 >= dp_ff.m[2]) ? mx01 : dp_ff.m[2];
      case (dp_ff.step[1:0])
         2'd0:    sq_op = dp_ff.m[0][NMAG_W-1:0];
         2'd1:    sq_op = dp_ff.m[1][NMAG_W-1:0];
         default: sq_op = dp_ff.m[2][NMAG_W-1:0];
      endcase
      case (dp_ff.comp)
         2'd0:    dv_m = dp_ff.m[0][NMAG_W-1:0];
         2'd1:    dv_m = dp_ff.m[1][NMAG_W-1:0];
         default: dv_m = dp_ff.m[2][NMAG_W-1:0];
      endcase
      srem_cat = {dp_ff.srem[SREM_W-3:0], dp_ff.x[SUM_W-1:SUM_W-2]};
      trial    = SREM_W'({dp_ff.root, 2'b01});
      num      = (NUM_W'(dv_m) << F) + NUM_W'(dp_ff.root >> 1);
      rcat     = {dp_ff.rem, dp_ff.qsh[QW-1]};
      dge      = rcat >= {1'b0, dp_ff.root};
      rdiv     = rcat - {1'b0, dp_ff.root};
   end

   always_comb begin
      state_in = state_ff;
      dp_in    = dp_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (dp_ff.done && rec_ready) begin
               dp_in.done = 1'b0;
            end
            if (req_tvalid && req_tready) begin
               for (int k = 0; k < VERTS; k++) begin
                  for (int i = 0; i < 3; i++) begin
                     dp_in.pos[k][i] = req_tdata[(k*3+i)*COORD_W +: COORD_W];
                  end
               end
               for (int i = 0; i < 3; i++) begin
                  dp_in.d1[i] = DIFF_W'($signed(req_tdata[(3+i)*COORD_W +: COORD_W]))
                              - DIFF_W'($signed(req_tdata[i*COORD_W +: COORD_W]));
                  dp_in.d2[i] = DIFF_W'($signed(req_tdata[(6+i)*COORD_W +: COORD_W]))
                              - DIFF_W'($signed(req_tdata[i*COORD_W +: COORD_W]));
               end
               dp_in.start    = req_tuser;
               dp_in.step     = '0;
               dp_in.prod_vld = 1'b0;
               dp_in.q        = '0;
               dp_in.degen    = 1'b0;
               state_in       = S_CROSS;
            end
         end
         S_CROSS: begin
            if (dp_ff.prod_vld) begin
               dp_in.c[acc_idx] = acc_new;
            end
            if (dp_ff.step == CROSS_LAST) begin
               dp_in.prod_vld = 1'b0;
               state_in       = S_ABS;
            end else begin
               dp_in.prod     = mul_p;
               dp_in.prod_vld = 1'b1;
               dp_in.prod_idx = dp_ff.step[2:0];
               dp_in.step     = dp_ff.step + 1'b1;
            end
         end
         S_ABS: begin
            for (int i = 0; i < 3; i++) begin
               dp_in.neg[i] = dp_ff.c[i][CROSS_W-1];
               dp_in.m[i]   = MAG_W'(dp_ff.c[i][CROSS_W-1] ? -$signed(dp_ff.c[i])
                                                         : $signed(dp_ff.c[i]));
            end
            state_in = S_MAX;
         end
         S_MAX: begin
            dp_in.mx = mxa;
            if (mxa == '0) begin
               dp_in.degen = 1'b1;
               dp_in.done  = 1'b1;
               state_in    = S_IDLE;
            end else begin
               state_in = S_NORM;
            end
         end
         S_NORM: begin
            if (dp_ff.mx >= NORM_HI) begin
               dp_in.mx = dp_ff.mx >> 1;
               for (int i = 0; i < 3; i++) dp_in.m[i] = dp_ff.m[i] >> 1;
            end else if (dp_ff.mx < NORM_LO) begin
               dp_in.mx = dp_ff.mx << 1;
               for (int i = 0; i < 3; i++) dp_in.m[i] = dp_ff.m[i] << 1;
            end else begin
               dp_in.step   = '0;
               dp_in.sum    = '0;
               dp_in.sq_vld = 1'b0;
               state_in     = S_SQUARE;
            end
         end
         S_SQUARE: begin
            if (dp_ff.sq_vld) begin
               dp_in.sum = dp_ff.sum + SUM_W'(dp_ff.sq);
            end
            if (dp_ff.step == SQUARE_LAST) begin
               dp_in.x    = dp_ff.sum + SUM_W'(dp_ff.sq);
               dp_in.root = '0;
               dp_in.srem = '0;
               dp_in.step = '0;
               state_in   = S_SQRT;
            end else begin
               dp_in.sq     = sq_op * sq_op;
               dp_in.sq_vld = 1'b1;
               dp_in.step   = dp_ff.step + 1'b1;
            end
         end
         S_SQRT: begin
            dp_in.x = dp_ff.x << 2;
            if (srem_cat >= trial) begin
               dp_in.srem = srem_cat - trial;
               dp_in.root = {dp_ff.root[ROOT_W-2:0], 1'b1};
            end else begin
               dp_in.srem = srem_cat;
               dp_in.root = {dp_ff.root[ROOT_W-2:0], 1'b0};
            end
            dp_in.step = dp_ff.step + 1'b1;
            if (dp_ff.step == SQRT_LAST) begin
               dp_in.comp = '0;
               state_in   = S_DLOAD;
            end
         end
         S_DLOAD: begin
            dp_in.rem  = ROOT_W'(num[NUM_W-1:F+1]);
            dp_in.qsh  = num[F:0];
            dp_in.step = '0;
            state_in   = S_DIV;
         end
         S_DIV: begin
            dp_in.rem  = ROOT_W'(dge ? rdiv : rcat);
            dp_in.qsh  = {dp_ff.qsh[QW-2:0], dge};
            dp_in.step = dp_ff.step + 1'b1;
            if (dp_ff.step == DIV_LAST) begin
               dp_in.q[dp_ff.comp] = {dp_ff.qsh[QW-2:0], dge};
               if (dp_ff.comp == 2'd2) begin
                  dp_in.done = 1'b1;
                  state_in   = S_IDLE;
               end else begin
                  dp_in.comp = dp_ff.comp + 1'b1;
                  state_in   = S_DLOAD;
               end
            end
         end
         default: begin
            state_in = S_PUSH_UNUSED;
         end
      endcase
   end

   // record towards the back end
   always_comb begin
      rec.pos   = dp_ff.pos;
      rec.degen = dp_ff.degen;
      rec.start = dp_ff.start;
      for (int i = 0; i < 3; i++) begin
         qext          = NRM_W'(dp_ff.q[i]);
         nfull         = dp_ff.neg[i] ? NRM_W'(~qext + 1'b1) : qext;
         rec.normal[i] = nfull[COORD_W-1:0];
      end
      qx = dp_ff.q[0];
      qy = dp_ff.q[1];
      qz = dp_ff.q[2];
      if (qx >= qy && qx >= qz) begin
         rec.axis = AXIS_X;
      end else if (qy >= qz) begin
         rec.axis = AXIS_Y;
      end else begin
         rec.axis = AXIS_Z;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         dp_ff    <= '0;
      end else begin
         state_ff <= state_in;
         dp_ff    <= dp_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (dp_ff.done && dp_ff.degen) |-> (dp_ff.q == '0))
      else $error("degenerate triangle with non-zero normal");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (dp_ff.root >= ROOT_W'(NORM_LO)))
      else $error("divider running with a length below range");
`endif

endmodule

FILE: design/tfn_queue.sv
// short queue of finished triangles between the front and back ends
module tfn_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_valid,
   output logic                 in_ready,
   input  tfn_pkg::tri_rec_type in_rec,
   output logic                 out_valid,
   input  logic                 out_pop,
   output tfn_pkg::tri_rec_type out_rec
);
   import tfn_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

   tri_rec_type      ent_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push, pop;

   assign in_ready  = count_ff != CNT_FULL;
   assign out_valid = count_ff != '0;
   assign out_rec   = ent_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_pop && out_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= in_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count beyond depth");
`endif

endmodule

FILE: design/tfn_back.sv
// back end: emits the three vertex results of each queued triangle
module tfn_back #(
   parameter int INDEX_WIDTH     = tfn_pkg::DEF_INDEX_WIDTH,
   parameter int COORD_FRAC_BITS = tfn_pkg::DEF_COORD_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           head_valid,
   output logic                           head_pop,
   input  tfn_pkg::tri_rec_type           head,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [tfn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tuser
);
   import tfn_pkg::*;

   localparam int F    = COORD_FRAC_BITS;
   localparam int TC_W = ((F > COORD_W) ? F : COORD_W) + 3;
   localparam int PAD_W = RSP_DATA_W - (6 * COORD_W + 2 * TEX_W + IDX_OUT_W);
   localparam logic [1:0] K_LAST = 2'd2;

   function automatic logic [TEX_W-1:0] tex_map(input logic [COORD_W-1:0] p);
      logic signed [TC_W-1:0] pe;
      logic signed [TC_W-1:0] one;
      logic signed [TC_W-1:0] t;
      pe  = TC_W'($signed(p));
      one = TC_W'(1) << F;
      t   = (pe + one + TC_W'(1)) >>> 1;
      if (pe < -one) begin
         t = '0;
      end else if (t > one) begin
         t = one;
      end
      return t[TEX_W-1:0];
   endfunction

   logic                          out_vld_ff, out_vld_in;
   logic [1:0]                    k_ff, k_in;
   logic [INDEX_WIDTH-1:0]        cnt_ff, cnt_in;
   logic [RSP_DATA_W-1:0]         data_ff, data_in;
   logic                          last_ff, last_in;
   logic                          degen_ff, degen_in;
   logic                          load;
   logic [2:0][COORD_W-1:0]       vpos;
   logic [COORD_W-1:0]            u_src, v_src;
   logic [INDEX_WIDTH-1:0]        idx_use;

   assign load       = head_valid && (!out_vld_ff || rsp_tready);
   assign head_pop   = load && (k_ff == K_LAST);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = degen_ff;

   always_comb begin
      vpos = head.pos[k_ff];
      unique case (head.axis)
         AXIS_X:  begin u_src = vpos[2]; v_src = vpos[1]; end
         AXIS_Y:  begin u_src = vpos[0]; v_src = vpos[2]; end
         default: begin u_src = vpos[0]; v_src = vpos[1]; end
      endcase
      idx_use = ((k_ff == 2'd0) && head.start) ? '0 : cnt_ff;
   end

   always_comb begin
      out_vld_in = out_vld_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      data_in    = data_ff;
      last_in    = last_ff;
      degen_in   = degen_ff;
      if (load) begin
         out_vld_in = 1'b1;
         k_in       = (k_ff == K_LAST) ? 2'd0 : k_ff + 1'b1;
         cnt_in     = idx_use + 1'b1;
         data_in    = {PAD_W'(0), IDX_OUT_W'(idx_use), tex_map(v_src), tex_map(u_src),
                       head.normal[2], head.normal[1], head.normal[0],
                       vpos[2], vpos[1], vpos[0]};
         last_in    = k_ff == K_LAST;
         degen_in   = head.degen;
      end else if (rsp_tready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      data_ff  <= data_in;
      last_ff  <= last_in;
      degen_ff <= degen_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
         k_ff       <= '0;
         cnt_ff     <= '0;
      end else begin
         out_vld_ff <= out_vld_in;
         k_ff       <= k_in;
         cnt_ff     <= cnt_in;
      end
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (k_ff == 2'd0))
      else $error("last vertex shown while triangle not finished");
   assert property (@(posedge clock) disable iff (reset)
      head_pop |-> (head_valid && k_ff == K_LAST))
      else $error("triangle released before its third vertex");
`endif

endmodule

FILE: design/triangle_face_normal_box_uv_unit.sv
// top level: triangle face normal with box-projected texture coordinates
// one request gives three results; the cross product is normalised by 0 to 29 shifts,
// then a bit-serial square root and divider give the unit normal
// zero-area triangles skip these steps; results leave one per cycle while rsp_tready is high
// the two-entry queue lets the next request be worked on while results drain
// synchronous active-high reset clears control state and the vertex index
module triangle_face_normal_box_uv_unit #(
   parameter int INDEX_WIDTH     = tfn_pkg::DEF_INDEX_WIDTH,
   parameter int COORD_FRAC_BITS = tfn_pkg::DEF_COORD_FRAC_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   input  logic [tfn_pkg::REQ_DATA_W-1:0] req_tdata,
   // start_of_mesh
   input  logic                           req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // pos_x, pos_y, pos_z, normal_x, normal_y, normal_z, tex_u, tex_v, vertex_index
   output logic [tfn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   // degenerate
   output logic                           rsp_tuser
);
   import tfn_pkg::*;

   tri_rec_type front_rec, head_rec;
   logic        front_valid, front_ready;
   logic        head_valid, head_pop;

   tfn_front #(
      .COORD_FRAC_BITS(COORD_FRAC_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rec_valid  (front_valid),
      .rec_ready  (front_ready),
      .rec        (front_rec)
   );

   tfn_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_rec    (front_rec),
      .out_valid (head_valid),
      .out_pop   (head_pop),
      .out_rec   (head_rec)
   );

   tfn_back #(
      .INDEX_WIDTH     (INDEX_WIDTH),
      .COORD_FRAC_BITS (COORD_FRAC_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_pop   (head_pop),
      .head       (head_rec),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

FILE: bench/tfn_checker.sv
// checker for the face normal unit: predicts vertex results per request and compares them
`timescale 1ns / 100ps
module tfn_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [tfn_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic                           req_tuser,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [tfn_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                           rsp_tlast,
   input  logic                           rsp_tuser,
   output int                             pending,
   output int                             fail_count,
   output int                             vertex_count,
   output int                             degen_count
);
   import tfn_pkg::*;

   localparam int FRAC = DEF_COORD_FRAC_BITS;

   typedef struct packed {
      logic [2:0][15:0] pos;
      logic [2:0][15:0] nrm;
      logic [14:0]      u;
      logic [14:0]      v;
      logic [15:0]      idx;
      logic             last;
      logic             degen;
   } vertex_rec;

   vertex_rec vertex_q[$];
   logic [15:0] index_count;

   function automatic longint unsigned int_root(input longint unsigned x);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic [14:0] box_tex(input longint p);
      longint one, t;
      one = longint'(1) << FRAC;
      if (p < -one) return 15'd0;
      t = (p + one + 1) >>> 1;
      if (t > one) t = one;
      return t[14:0];
   endfunction

   task automatic predict_vertices(input logic [REQ_DATA_W-1:0] d, input logic s);
      longint p[3][3];
      longint d1[3], d2[3], c[3], n[3];
      longint unsigned m[3], mx, sum, len, r, ax, ay, az;
      axis_type axis;
      int ua, va;
      logic degen;
      vertex_rec e;
      for (int k = 0; k < 3; k++)
         for (int i = 0; i < 3; i++)
            p[k][i] = longint'($signed(d[(k*3+i)*16 +: 16]));
      if (s) index_count = 0;
      for (int i = 0; i < 3; i++) begin
         d1[i] = p[1][i] - p[0][i];
         d2[i] = p[2][i] - p[0][i];
      end
      c[0] = d1[1] * d2[2] - d1[2] * d2[1];
      c[1] = d1[2] * d2[0] - d1[0] * d2[2];
      c[2] = d1[0] * d2[1] - d1[1] * d2[0];
      mx = 0;
      for (int i = 0; i < 3; i++) begin
         m[i] = c[i] < 0 ? longint'(-c[i]) : longint'(c[i]);
         if (m[i] > mx) mx = m[i];
         n[i] = 0;
      end
      degen = (mx == 0);
      if (!degen) begin
         while (mx >= (64'd1 << 30)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
         end
         while (mx < (64'd1 << 29)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
         end
         sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
         len = int_root(sum);
         for (int i = 0; i < 3; i++) begin
            r = ((m[i] << FRAC) + len / 2) / len;
            n[i] = c[i] < 0 ? -longint'(r) : longint'(r);
         end
      end
      ax = n[0] < 0 ? -n[0] : n[0];
      ay = n[1] < 0 ? -n[1] : n[1];
      az = n[2] < 0 ? -n[2] : n[2];
      if (ax >= ay && ax >= az) axis = AXIS_X;
      else if (ay >= az)        axis = AXIS_Y;
      else                      axis = AXIS_Z;
      case (axis)
         AXIS_X: begin ua = 2; va = 1; end
         AXIS_Y: begin ua = 0; va = 2; end
         default: begin ua = 0; va = 1; end
      endcase
      for (int k = 0; k < 3; k++) begin
         for (int i = 0; i < 3; i++) begin
            e.pos[i] = p[k][i][15:0];
            e.nrm[i] = n[i][15:0];
         end
         e.u     = box_tex(p[k][ua]);
         e.v     = box_tex(p[k][va]);
         e.idx   = index_count;
         e.last  = (k == 2);
         e.degen = degen;
         vertex_q.insert(vertex_q.size(), e);
         index_count = index_count + 16'd1;
      end
   endtask

   always @(posedge clock) begin
      vertex_rec got, exp_v;
      if (reset) begin
         index_count = 0;
      end else begin
         if (req_tvalid && req_tready) predict_vertices(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) begin
            for (int i = 0; i < 3; i++) begin
               got.pos[i] = rsp_tdata[i*16 +: 16];
               got.nrm[i] = rsp_tdata[48 + i*16 +: 16];
            end
            got.u     = rsp_tdata[110:96];
            got.v     = rsp_tdata[125:111];
            got.idx   = rsp_tdata[141:126];
            got.last  = rsp_tlast;
            got.degen = rsp_tuser;
            vertex_count++;
            if (vertex_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t unexpected vertex result %h", $time, got);
            end else begin
               exp_v = vertex_q.pop_front();
               if (exp_v.degen) degen_count++;
               if (got.pos != exp_v.pos || got.nrm != exp_v.nrm || got.u != exp_v.u ||
                   got.v != exp_v.v || got.idx != exp_v.idx || got.last != exp_v.last ||
                   got.degen != exp_v.degen) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t vertex %0d: exp pos %h nrm %h uv %h/%h idx %0d l%b d%b, got pos %h nrm %h uv %h/%h idx %0d l%b d%b",
                        $time, vertex_count, exp_v.pos, exp_v.nrm, exp_v.u, exp_v.v,
                        exp_v.idx, exp_v.last, exp_v.degen, got.pos, got.nrm, got.u,
                        got.v, got.idx, got.last, got.degen);
               end
            end
         end
      end
      pending = vertex_q.size();
   end

   initial begin
      pending = 0;
      fail_count = 0;
      vertex_count = 0;
      degen_count = 0;
      index_count = 0;
   end

endmodule

FILE: bench/tb.sv
// testbench top: drives triangles and result stalls, gives the verdict
`timescale 1ns / 100ps
module tb;
   import tfn_pkg::*;

   localparam int WATCH_LIMIT = 5000;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic                  req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   int pending, fail_count, vertex_count, degen_count;
   int burst_left, idle_cycles, tri_count, mesh_count;

   triangle_face_normal_box_uv_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser)
   );

   tfn_checker chk (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast), .rsp_tuser(rsp_tuser),
      .pending(pending), .fail_count(fail_count),
      .vertex_count(vertex_count), .degen_count(degen_count)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCH_LIMIT) begin
         $display("watchdog expired with %0d results outstanding", pending);
         $display("triangle_face_normal_box_uv_unit: mismatch");
         $finish;
      end
   end

   // receiver stall pattern, switching at random among four modes
   initial begin
      int phase, mode;
      rsp_tready = 0;
      phase = 0;
      mode = 0;
      forever begin
         @(negedge clock);
         if (phase % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_tready = 1;
            1: rsp_tready = ($urandom_range(0, 9) < 7);
            2: rsp_tready = (phase % 8) < 3;
            default: rsp_tready = ($urandom_range(0, 9) < 2);
         endcase
         phase++;
      end
   end

   function automatic logic [15:0] any_coord();
      if ($urandom_range(0, 19) == 0) return 16'($urandom);
      return 16'($urandom_range(0, 32768) - 16384);
   endfunction

   // called at a falling edge, returns after the rising edge that takes the request
   task automatic send_triangle(input logic [15:0] v[9], input logic s);
      if (burst_left == 0) begin
         int gap;
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         req_tvalid = 0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 10);
      end
      for (int i = 0; i < 9; i++) req_tdata[i*16 +: 16] = v[i];
      req_tuser = s;
      req_tvalid = 1;
      #1;
      while (!req_tready) begin
         @(negedge clock);
         #1;
      end
      @(posedge clock);
      @(negedge clock);
      req_tvalid = 0;
      burst_left--;
      tri_count++;
      if (s) mesh_count++;
   endtask

   task automatic send_coords(input int ax, ay, az, bx, by, bz, cx, cy, cz, input logic s);
      logic [15:0] v[9];
      v = '{16'(ax), 16'(ay), 16'(az), 16'(bx), 16'(by), 16'(bz), 16'(cx), 16'(cy), 16'(cz)};
      send_triangle(v, s);
   endtask

   initial begin
      logic [15:0] v[9];
      int kind, scale;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      req_tuser = 0;
      burst_left = 0;
      idle_cycles = 0;
      tri_count = 0;
      mesh_count = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: zero area, axis picks and ties, extremes, mesh restarts
      send_coords(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
      send_coords(100, 200, 300, 100, 200, 300, 500, -7, 9, 0);
      send_coords(0, 0, 0, 1000, 1000, 1000, 2000, 2000, 2000, 0);
      send_coords(0, 0, 0, 0, 16384, 0, 0, 0, 16384, 0);
      send_coords(0, 0, 0, 0, 0, 16384, 16384, 0, 0, 0);
      send_coords(0, 0, 0, 16384, 0, 0, 0, 16384, 0, 1);
      send_coords(0, 0, 0, 0, 16384, -16384, 16384, 0, -16384, 0);
      send_coords(0, 0, 0, 16384, 0, -16384, 0, 16384, -16384, 0);
      send_coords(0, 0, 0, 16384, 16384, 0, 0, 16384, 16384, 0);
      send_coords(-16384, -16384, -16384, 16384, -16384, 16384, -16384, 16384, 16384, 0);
      send_coords(16384, 16384, 16384, -16384, 16384, -16384, 16384, -16384, -16384, 1);
      send_coords(-16384, 16384, -16384, 16384, -16384, 16384, 16384, 16384, -16384, 0);
      send_coords(0, 0, 0, 1, 0, 0, 0, 1, 0, 0);
      send_coords(5, 5, 5, 6, 5, 5, 5, 5, 6, 0);
      send_coords(-32768, 32767, 0, 32767, -32768, 100, 0, 0, -32768, 0);
      send_coords(-20000, 20000, -16385, -16384, 16383, 1, 18000, -18000, 5, 0);
      send_coords(0, 0, 0, 3, 4, 0, -4, 3, 0, 1);
      send_coords(16383, -1, 1, -1, 16383, 1, 1, 1, -16383, 0);

      @(negedge clock);
      while (pending != 0) @(negedge clock);

      for (int n = 0; n < 480; n++) begin
         kind = $urandom_range(0, 19);
         for (int i = 0; i < 9; i++) v[i] = any_coord();
         if (kind < 2) begin
            // a repeated vertex gives zero area
            for (int i = 0; i < 3; i++) v[3 + $urandom_range(0, 1) * 3 + i] = v[i];
         end else if (kind < 6) begin
            // small triangles around a point need long normalising shifts
            scale = $urandom_range(0, 6);
            for (int i = 3; i < 9; i++)
               v[i] = v[i % 3] + 16'($signed(($urandom_range(0, 2 << scale)) - (1 << scale)));
         end
         send_triangle(v, $urandom_range(0, 24) == 0);
         if (n == 240) begin
            while (pending != 0) @(negedge clock);
         end
      end

      while (pending != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("%0d triangles in %0d meshes gave %0d vertex results, %0d of them zero area",
         tri_count, mesh_count, vertex_count, degen_count);
      $display("random triangles, repeated vertices, small areas and saturating coordinates");
      if (fail_count == 0 && pending == 0)
         $display("triangle_face_normal_box_uv_unit: match");
      else
         $display("triangle_face_normal_box_uv_unit: mismatch");
      $finish;
   end

endmodule

FILE: triangle_face_normal_box_uv_unit.f
design/tfn_pkg.sv
design/tfn_front.sv
design/tfn_queue.sv
design/tfn_back.sv
design/triangle_face_normal_box_uv_unit.sv
bench/tfn_checker.sv
bench/tb.sv
